FILE: hw/rtl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Types and constants shared by the multi-server queue event simulator.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int MaxServersDef = 16;
    localparam int MaxWaitingDef = 64;
    localparam int CfgW          = 7;
    localparam int TimeW         = 32;
    localparam int SvcW          = 24;
    localparam int AreaW         = 48;
    localparam int CntW          = 32;

    localparam logic [0:0] CfgServerCount   = 1'b0;
    localparam logic [0:0] CfgQueueCapacity = 1'b1;

    localparam logic CmdArrival = 1'b0;
    localparam logic CmdDrain   = 1'b1;

    typedef enum logic [1:0] {
        OUT_SERVED = 2'd0,
        OUT_QUEUED = 2'd1,
        OUT_DROPPED = 2'd2,
        OUT_DRAINED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic              command;
        logic [TimeW-1:0]  arrival_time;
        logic [SvcW-1:0]   service_time;
    } item_t;

    typedef struct packed {
        outcome_t          outcome;
        logic [TimeW-1:0]  now_time;
        logic [AreaW-1:0]  system_area;
        logic [AreaW-1:0]  queue_area;
        logic [CntW-1:0]   finished_count;
        logic [CntW-1:0]   dropped_count;
        logic [CntW-1:0]   arrival_count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_RETIRE,
        ST_RET_MUL,
        ST_RET_ADD,
        ST_RET_MOVE,
        ST_RET_FIFO,
        ST_RET_REFILL,
        ST_ARR_MUL,
        ST_ARR_ADD,
        ST_ARR_PLACE,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/multi_server_queue_event_sim.sv
// ----------------------------------------------------------------------------
// multi_server_queue_event_sim
// Event-driven multi-server queue with waiting FIFO and area totals.
// ----------------------------------------------------------------------------
// Use: raise start with in_item while busy is low; the beat is taken at that
// edge. One result beat follows, marked by out_valid for one cycle; the
// receiver cannot stall it. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the next edge; write them only while busy is low.
// Timing: departure times live in a memory of MAX_SERVERS entries, waiting
// service times in a memory of MAX_WAITING entries, each with a registered
// read. Each pass first scans the serving entries for the earliest
// departure, one entry per cycle; a retirement then updates the area
// totals, moves the last serving entry into the freed slot and refills
// from the FIFO before the next scan. An arrival ends with one scan, then
// area update, placement and the result beat; a drain repeats retirements
// until no customer serves and then gives its result beat. A new beat
// may be taken in the cycle of the result beat. Reset clears all counters
// and totals; the memories need no clearing since only written entries are
// read.
// ----------------------------------------------------------------------------
module multi_server_queue_event_sim
    import msq_pkg::*;
#(
    parameter int MAX_SERVERS = MaxServersDef,
    parameter int MAX_WAITING = MaxWaitingDef
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  item_t           in_item,
    output logic            out_valid,
    output result_t         out_result,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    localparam int SrvIdxW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SrvCntW = $clog2(MAX_SERVERS + 1);
    localparam int WIdxW   = (MAX_WAITING > 1) ? $clog2(MAX_WAITING) : 1;
    localparam int WCntW   = $clog2(MAX_WAITING + 1);
    localparam int SysCntW = $clog2(MAX_SERVERS + MAX_WAITING + 1);
    localparam logic [TimeW-1:0] TimeMax = '1;
    localparam logic [CntW-1:0]  CntMax  = '1;

    logic [TimeW-1:0] heap_mem [MAX_SERVERS];
    logic [SvcW-1:0]  fifo_mem [MAX_WAITING];

    state_t state_reg, state_next;

    logic [4:0]       srv_cfg_reg;
    logic [CfgW-1:0]  cap_cfg_reg;
    item_t            item_reg;
    logic [TimeW-1:0] t_reg;
    logic [SrvCntW-1:0] serving_reg;
    logic [WIdxW-1:0] head_reg;
    logic [WCntW-1:0] fcount_reg;
    logic [TimeW-1:0] now_reg;
    logic [CntW-1:0]  dep_reg, drop_reg, arr_reg;
    outcome_t         outcome_reg;

    logic [SrvCntW-1:0] scan_reg;
    logic [SrvIdxW-1:0] best_idx_reg;
    logic [TimeW-1:0]   best_val_reg;
    logic [TimeW-1:0]   target_reg;
    logic [SysCntW-1:0] sys_cnt_reg;
    logic [TimeW-1:0]   heap_rd;
    logic [SvcW-1:0]    fifo_rd;

    logic               heap_we;
    logic [SrvIdxW-1:0] heap_wa, heap_ra;
    logic [TimeW-1:0]   heap_wd;
    logic               fifo_we;
    logic [WIdxW-1:0]   fifo_wa;

    logic [AreaW-1:0] sys_total, q_total;
    logic             mul_en, add_en;

    logic [SrvCntW-1:0] srv_lim;
    logic [WCntW-1:0]   cap_lim;
    logic [WIdxW:0]     tail_sum;
    logic [TimeW:0]     dep_sum;
    logic [TimeW-1:0]   dep_time;
    logic               fifo_wait;

    always_comb
    begin
        if (srv_cfg_reg == '0)
            srv_lim = SrvCntW'(1);
        else if (32'(srv_cfg_reg) > MAX_SERVERS)
            srv_lim = SrvCntW'(MAX_SERVERS);
        else
            srv_lim = SrvCntW'(srv_cfg_reg);
        if (32'(cap_cfg_reg) > MAX_WAITING)
            cap_lim = WCntW'(MAX_WAITING);
        else
            cap_lim = WCntW'(cap_cfg_reg);
        tail_sum = {1'b0, head_reg} + (WIdxW+1)'(fcount_reg);
        if (32'(tail_sum) >= MAX_WAITING)
            fifo_wa = WIdxW'(32'(tail_sum) - MAX_WAITING);
        else
            fifo_wa = tail_sum[WIdxW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start) state_next = ST_SCAN_RD;
            ST_SCAN_RD:
                if (serving_reg == '0) state_next = ST_DECIDE;
                else state_next = ST_SCAN;
            ST_SCAN:
                if (scan_reg == serving_reg) state_next = ST_DECIDE;
            ST_DECIDE:
                if (serving_reg != '0 &&
                    (item_reg.command == CmdDrain || best_val_reg <= t_reg))
                    state_next = ST_RETIRE;
                else if (item_reg.command == CmdDrain)
                    state_next = ST_DONE;
                else
                    state_next = ST_ARR_MUL;
            ST_RETIRE:     state_next = ST_RET_MUL;
            ST_RET_MUL:    state_next = ST_RET_ADD;
            ST_RET_ADD:    state_next = ST_RET_MOVE;
            ST_RET_MOVE:   state_next = ST_RET_FIFO;
            ST_RET_FIFO:   state_next = ST_RET_REFILL;
            ST_RET_REFILL: state_next = ST_SCAN_RD;
            ST_ARR_MUL:    state_next = ST_ARR_ADD;
            ST_ARR_ADD:    state_next = ST_ARR_PLACE;
            ST_ARR_PLACE:  state_next = ST_DONE;
            ST_DONE:       state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_en  = (state_reg == ST_RET_MUL) || (state_reg == ST_ARR_MUL);
        add_en  = (state_reg == ST_RET_ADD) || (state_reg == ST_ARR_ADD);
        busy    = (state_reg != ST_IDLE);
        heap_ra = (state_reg == ST_RET_ADD) ? SrvIdxW'(serving_reg - 1'b1)
                : (state_reg == ST_SCAN_RD) ? '0
                                            : SrvIdxW'(scan_reg);
        dep_sum  = {1'b0, now_reg} + (TimeW+1)'(
                   (state_reg == ST_RET_REFILL) ? fifo_rd : item_reg.service_time);
        dep_time = dep_sum[TimeW] ? TimeMax : dep_sum[TimeW-1:0];
        heap_we = 1'b0;
        heap_wa = best_idx_reg;
        heap_wd = heap_rd;
        fifo_we = 1'b0;
        case (state_reg)
            ST_RET_MOVE:
                heap_we = 1'b1;
            ST_RET_REFILL:
            begin
                heap_we = fifo_wait;
                heap_wa = SrvIdxW'(serving_reg);
                heap_wd = dep_time;
            end
            ST_ARR_PLACE:
            begin
                heap_we = (serving_reg < srv_lim);
                heap_wa = SrvIdxW'(serving_reg);
                heap_wd = dep_time;
                fifo_we = (serving_reg >= srv_lim) && (fcount_reg < cap_lim);
            end
            default:
                heap_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        heap_rd <= heap_mem[heap_ra];
        if (fifo_we)
            fifo_mem[fifo_wa] <= item_reg.service_time;
        fifo_rd <= fifo_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            srv_cfg_reg <= 5'd1;
            cap_cfg_reg <= '0;
            serving_reg <= '0;
            head_reg    <= '0;
            fcount_reg  <= '0;
            now_reg     <= '0;
            dep_reg     <= '0;
            drop_reg    <= '0;
            arr_reg     <= '0;
            out_valid   <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_reg == ST_DONE);
            if (cfg_we && cfg_index == CfgServerCount)
                srv_cfg_reg <= cfg_data[4:0];
            if (cfg_we && cfg_index == CfgQueueCapacity)
                cap_cfg_reg <= cfg_data;
            case (state_reg)
                ST_SCAN_RD:
                    scan_reg <= SrvCntW'(1);
                ST_SCAN:
                    if (scan_reg != serving_reg)
                        scan_reg <= scan_reg + 1'b1;
                ST_RET_MOVE:
                begin
                    serving_reg <= serving_reg - 1'b1;
                    if (dep_reg != CntMax) dep_reg <= dep_reg + 1'b1;
                end
                ST_RET_REFILL:
                begin
                    if (fifo_wait)
                    begin
                        serving_reg <= serving_reg + 1'b1;
                        fcount_reg  <= fcount_reg - 1'b1;
                        if (32'(head_reg) + 1 >= MAX_WAITING)
                            head_reg <= '0;
                        else
                            head_reg <= head_reg + 1'b1;
                    end
                end
                ST_ARR_PLACE:
                begin
                    if (arr_reg != CntMax) arr_reg <= arr_reg + 1'b1;
                    if (serving_reg < srv_lim)
                        serving_reg <= serving_reg + 1'b1;
                    else if (fcount_reg < cap_lim)
                        fcount_reg <= fcount_reg + 1'b1;
                    else if (drop_reg != CntMax)
                        drop_reg <= drop_reg + 1'b1;
                end
                default:
                    scan_reg <= scan_reg;
            endcase
            if (state_reg == ST_RET_ADD || state_reg == ST_ARR_ADD)
                if (target_reg > now_reg) now_reg <= target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            item_reg <= in_item;
        if (state_reg == ST_SCAN_RD)
        begin
            t_reg <= (item_reg.arrival_time < now_reg) ? now_reg
                                                       : item_reg.arrival_time;
            best_idx_reg <= '0;
        end
        if (state_reg == ST_SCAN && scan_reg == SrvCntW'(1))
            best_val_reg <= heap_rd;
        else if (state_reg == ST_SCAN && heap_rd < best_val_reg)
        begin
            best_val_reg <= heap_rd;
            best_idx_reg <= SrvIdxW'(scan_reg - 1'b1);
        end
        if (state_reg == ST_RETIRE)
            target_reg <= best_val_reg;
        else if (state_reg == ST_DECIDE)
            target_reg <= t_reg;
        if (state_reg == ST_RETIRE || state_reg == ST_DECIDE)
        begin
            sys_cnt_reg <= SysCntW'(serving_reg) + SysCntW'(fcount_reg);
        end
        if (state_reg == ST_DONE)
        begin
            out_result.outcome        <= outcome_reg;
            out_result.now_time       <= now_reg;
            out_result.system_area    <= sys_total;
            out_result.queue_area     <= q_total;
            out_result.finished_count <= dep_reg;
            out_result.dropped_count  <= drop_reg;
            out_result.arrival_count  <= arr_reg;
        end
        if (state_reg == ST_ARR_PLACE)
        begin
            if (serving_reg < srv_lim) outcome_reg <= OUT_SERVED;
            else if (fcount_reg < cap_lim) outcome_reg <= OUT_QUEUED;
            else outcome_reg <= OUT_DROPPED;
        end
        else if (state_reg == ST_DECIDE && item_reg.command == CmdDrain)
            outcome_reg <= OUT_DRAINED;
    end

    logic [TimeW-1:0] dt_mul;
    assign dt_mul = (target_reg > now_reg) ? (target_reg - now_reg) : '0;

    msq_area_acc #(.CountW(SysCntW)) u_sys_acc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .mul_en(mul_en),
        .add_en(add_en),
        .count (sys_cnt_reg),
        .dt    (dt_mul),
        .total (sys_total)
    );

    msq_area_acc #(.CountW(WCntW)) u_q_acc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .mul_en(mul_en),
        .add_en(add_en),
        .count (fcount_reg),
        .dt    (dt_mul),
        .total (q_total)
    );

    // retire refill only when waiting customers exist
    assign fifo_wait = (fcount_reg != '0);

    a_serving_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(serving_reg) <= MAX_SERVERS)
        else $error("serving count above server limit");

    a_fifo_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fcount_reg) <= MAX_WAITING)
        else $error("fifo count above capacity");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("result beat longer than one cycle");

endmodule

FILE: hw/rtl/msq_area_acc.sv
// ----------------------------------------------------------------------------
// msq_area_acc
// Saturating accumulator for one time-weighted count total.
// ----------------------------------------------------------------------------
module msq_area_acc
    import msq_pkg::*;
#(
    parameter int CountW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mul_en,
    input  logic              add_en,
    input  logic [CountW-1:0] count,
    input  logic [TimeW-1:0]  dt,
    output logic [AreaW-1:0]  total
);

    localparam int ProdW = CountW + TimeW;

    logic [ProdW-1:0] prod_reg;
    logic [AreaW-1:0] total_reg;
    logic [AreaW-1:0] total_next;
    logic [AreaW:0]   sum;

    localparam logic [AreaW-1:0] AreaMax = '1;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= ProdW'(count) * ProdW'(dt);
        end
    end

    always_comb
    begin
        sum = {1'b0, total_reg} + (AreaW+1)'(prod_reg);
        if ((ProdW > AreaW) && ((prod_reg >> AreaW) != '0))
        begin
            total_next = AreaMax;
        end
        else if (sum[AreaW] || (sum[AreaW-1:0] == AreaMax))
        begin
            total_next = AreaMax;
        end
        else
        begin
            total_next = sum[AreaW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (add_en)
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

FILE: bench/multi_server_queue_event_sim_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_server_queue_event_sim_tb
// Self-checking bench for the multi-server queue event simulator. A short
// table of directed beats runs first, followed by random arrivals and drains
// under several server and waiting-room settings, the extremes included.
// Each result beat is checked field by field against its table row's value
// if typed, else against a queue predictor kept in step with each accepted beat.
// ----------------------------------------------------------------------------
module multi_server_queue_event_sim_tb;
    import msq_pkg::*;

    localparam logic [47:0] AreaMax = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } row_t;

    typedef struct {
        int  servers;
        int  places;
        int  beats;
        bit  idles;
        bit  late_clock;
    } phase_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    item_t           in_item;
    logic            out_valid;
    result_t         out_result;
    logic            cfg_we;
    logic [0:0]      cfg_index;
    logic [CfgW-1:0] cfg_data;

    // queue model state
    logic [TimeW-1:0] dep_time [MaxServersDef];
    int               n_serving;
    logic [SvcW-1:0]  wait_svc [MaxWaitingDef];
    int               wait_head;
    int               n_waiting;
    logic [TimeW-1:0] clock_now;
    logic [AreaW-1:0] sys_area;
    logic [AreaW-1:0] wait_area;
    logic [CntW-1:0]  n_finished;
    logic [CntW-1:0]  n_dropped;
    logic [CntW-1:0]  n_arrived;
    int               reg_servers;
    int               reg_places;

    result_t pending_results[$];
    int      errors;
    int      n_checked;
    int      seen_outcome[4];
    bit      idle_on;

    multi_server_queue_event_sim dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_result (out_result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [AreaW-1:0] area_sum(logic [AreaW-1:0] total,
                                                  logic [63:0] add);
        if (total >= AreaMax || add >= {16'd0, AreaMax - total})
            return AreaMax;
        return total + add[AreaW-1:0];
    endfunction

    function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [TimeW-1:0] finish_at(logic [TimeW-1:0] t0,
                                                   logic [SvcW-1:0] svc);
        logic [TimeW:0] d;
        d = {1'b0, t0} + {9'd0, svc};
        return d[TimeW] ? '1 : d[TimeW-1:0];
    endfunction

    function automatic void advance_clock(logic [TimeW-1:0] t);
        logic [63:0] dt;
        dt = (t > clock_now) ? 64'(t - clock_now) : 64'd0;
        sys_area  = area_sum(sys_area, 64'(n_serving + n_waiting) * dt);
        wait_area = area_sum(wait_area, 64'(n_waiting) * dt);
        if (t > clock_now)
            clock_now = t;
    endfunction

    function automatic int first_departure();
        int best;
        best = 0;
        for (int i = 1; i < n_serving; i++)
            if (dep_time[i] < dep_time[best])
                best = i;
        return best;
    endfunction

    function automatic void retire_customer();
        int k;
        k = first_departure();
        advance_clock(dep_time[k]);
        n_serving--;
        dep_time[k] = dep_time[n_serving];
        n_finished = bump(n_finished);
        if (n_waiting > 0 && n_serving < MaxServersDef)
        begin
            dep_time[n_serving] = finish_at(clock_now, wait_svc[wait_head]);
            n_serving++;
            wait_head = (wait_head + 1) % MaxWaitingDef;
            n_waiting--;
        end
    endfunction

    function automatic result_t queue_step(item_t it);
        result_t r;
        logic [TimeW-1:0] t;
        int srv;
        int cap;
        if (it.command == CmdDrain)
        begin
            while (n_serving > 0)
                retire_customer();
            r.outcome = OUT_DRAINED;
        end
        else
        begin
            srv = (reg_servers < 1) ? 1 : (reg_servers > MaxServersDef) ? MaxServersDef
                                                                       : reg_servers;
            cap = (reg_places > MaxWaitingDef) ? MaxWaitingDef : reg_places;
            t = (it.arrival_time < clock_now) ? clock_now : it.arrival_time;
            while (n_serving > 0 && dep_time[first_departure()] <= t)
                retire_customer();
            advance_clock(t);
            n_arrived = bump(n_arrived);
            if (n_serving < srv)
            begin
                dep_time[n_serving] = finish_at(clock_now, it.service_time);
                n_serving++;
                r.outcome = OUT_SERVED;
            end
            else if (n_waiting < cap)
            begin
                wait_svc[(wait_head + n_waiting) % MaxWaitingDef] = it.service_time;
                n_waiting++;
                r.outcome = OUT_QUEUED;
            end
            else
            begin
                n_dropped = bump(n_dropped);
                r.outcome = OUT_DROPPED;
            end
        end
        r.now_time       = clock_now;
        r.system_area    = sys_area;
        r.queue_area     = wait_area;
        r.finished_count = n_finished;
        r.dropped_count  = n_dropped;
        r.arrival_count  = n_arrived;
        return r;
    endfunction

    task automatic send_beat(item_t it, bit typed, result_t want);
        result_t predicted;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predicted = queue_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        int guard;
        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while ((pending_results.size() != 0 || busy) && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CfgW-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgServerCount)
            reg_servers = value & 5'h1F;
        else
            reg_places = value & 7'h7F;
    endtask

    function automatic item_t random_beat(bit late_clock);
        item_t it;
        int    r;
        int    srv;
        srv = (reg_servers < 1) ? 1 : (reg_servers > MaxServersDef) ? MaxServersDef
                                                                   : reg_servers;
        it.command = ($urandom_range(0, 99) < 5) ? CmdDrain : CmdArrival;
        r = $urandom_range(0, 99);
        if (late_clock && clock_now < 32'hFFFF_0000)
            it.arrival_time = 32'hFFFF_0000 + $urandom_range(0, 255);
        else if (late_clock && r < 15)
            it.arrival_time = $urandom;
        else if (r < 8)
            it.arrival_time = clock_now - $urandom_range(0, 50);
        else
            it.arrival_time = clock_now + $urandom_range(0, 40);
        r = $urandom_range(0, 99);
        if (r < 3)
            it.service_time = '1;
        else if (r < 8)
            it.service_time = '0;
        else if (r < 10)
            it.service_time = SvcW'($urandom);
        else
            it.service_time = SvcW'($urandom_range(0, 30 * srv));
        return it;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (out_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, out_result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                seen_outcome[out_result.outcome]++;
                if (out_result.outcome !== want.outcome)
                    $display("%0t: outcome exp %s got %s", $time, want.outcome.name(),
                             out_result.outcome.name());
                if (out_result.now_time !== want.now_time)
                    $display("%0t: now_time exp %0d got %0d", $time, want.now_time,
                             out_result.now_time);
                if (out_result.system_area !== want.system_area)
                    $display("%0t: system_area exp %0d got %0d", $time,
                             want.system_area, out_result.system_area);
                if (out_result.queue_area !== want.queue_area)
                    $display("%0t: queue_area exp %0d got %0d", $time,
                             want.queue_area, out_result.queue_area);
                if (out_result.finished_count !== want.finished_count)
                    $display("%0t: finished_count exp %0d got %0d", $time,
                             want.finished_count, out_result.finished_count);
                if (out_result.dropped_count !== want.dropped_count)
                    $display("%0t: dropped_count exp %0d got %0d", $time,
                             want.dropped_count, out_result.dropped_count);
                if (out_result.arrival_count !== want.arrival_count)
                    $display("%0t: arrival_count exp %0d got %0d", $time,
                             want.arrival_count, out_result.arrival_count);
                if (out_result !== want)
                    errors++;
            end
        end
    end

    initial
    begin
        row_t   rows[$];
        phase_t phases[$];
        int     guard;

        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CfgServerCount;
        cfg_data  = '0;
        rst_n     = 1'b0;
        errors    = 0;
        n_checked = 0;
        idle_on   = 1'b1;

        n_serving   = 0;
        wait_head   = 0;
        n_waiting   = 0;
        clock_now   = '0;
        sys_area    = '0;
        wait_area   = '0;
        n_finished  = '0;
        n_dropped   = '0;
        n_arrived   = '0;
        reg_servers = 1;
        reg_places  = 0;

        rows.push_back('{'{CmdArrival, 32'd0, 24'd0}, 1'b1,
                         '{OUT_SERVED, 32'd0, 48'd0, 48'd0, 32'd0, 32'd0, 32'd1}});
        rows.push_back('{'{CmdArrival, 32'd10, 24'd5}, 1'b1,
                         '{OUT_SERVED, 32'd10, 48'd0, 48'd0, 32'd1, 32'd0, 32'd2}});
        rows.push_back('{'{CmdArrival, 32'd12, 24'd1}, 1'b1,
                         '{OUT_DROPPED, 32'd12, 48'd2, 48'd0, 32'd1, 32'd1, 32'd3}});
        rows.push_back('{'{CmdDrain, 32'hFFFF_FFFF, 24'hFF_FFFF}, 1'b1,
                         '{OUT_DRAINED, 32'd15, 48'd5, 48'd0, 32'd2, 32'd1, 32'd3}});
        rows.push_back('{'{CmdDrain, 32'd0, 24'd0}, 1'b1,
                         '{OUT_DRAINED, 32'd15, 48'd5, 48'd0, 32'd2, 32'd1, 32'd3}});
        rows.push_back('{'{CmdArrival, 32'd3, 24'd7}, 1'b0, '0});
        rows.push_back('{'{CmdArrival, 32'd22, 24'd0}, 1'b0, '0});
        rows.push_back('{'{CmdArrival, 32'd22, 24'hFF_FFFF}, 1'b0, '0});
        rows.push_back('{'{CmdArrival, 32'd40, 24'd9}, 1'b0, '0});
        rows.push_back('{'{CmdDrain, 32'd0, 24'd0}, 1'b0, '0});
        rows.push_back('{'{CmdArrival, 32'h00FF_FFFF, 24'h55_AAAA}, 1'b0, '0});
        rows.push_back('{'{CmdDrain, 32'h5555_AAAA, 24'hAA_5555}, 1'b0, '0});

        phases.push_back('{16, 64, 220, 1'b0, 1'b0});
        phases.push_back('{31, 127, 150, 1'b1, 1'b0});
        phases.push_back('{0, 0, 100, 1'b1, 1'b0});
        phases.push_back('{4, 8, 200, 1'b1, 1'b0});
        phases.push_back('{2, 3, 200, 1'b1, 1'b0});
        phases.push_back('{1, 1, 80, 1'b1, 1'b0});
        phases.push_back('{16, 64, 120, 1'b1, 1'b1});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        settle();

        foreach (phases[p])
        begin
            write_reg(CfgServerCount, phases[p].servers);
            write_reg(CfgQueueCapacity, phases[p].places);
            idle_on = phases[p].idles;
            for (int n = 0; n < phases[p].beats; n++)
            begin
                send_beat(random_beat(phases[p].late_clock), 1'b0, '0);
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
            settle();
        end

        guard = 0;
        while (pending_results.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);

        $display("Checked %0d result beats: %0d served, %0d queued, %0d dropped, %0d drains",
                 n_checked, seen_outcome[0], seen_outcome[1], seen_outcome[2],
                 seen_outcome[3]);
        $display("Final clock %0h, %0d customers finished", clock_now, n_finished);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
